@@ src/bsfb_pkg.sv @@
// Shared types, constants and helpers for the byte-stuffed frame builder.
package bsfb_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SOF1_BYTE  = 8'h5A;
	localparam logic [7:0] SOF2_BYTE  = 8'h55;
	localparam logic [7:0] CR_BYTE    = 8'h0D;
	localparam logic [7:0] ESC_BYTE   = 8'h99;
	localparam logic [7:0] EOF1_BYTE  = 8'h6A;
	localparam logic [7:0] EOF2_BYTE  = 8'h69;
	localparam logic [7:0] ESC_SOF    = 8'hA5;
	localparam logic [7:0] ESC_ESC    = 8'h66;
	localparam logic [7:0] ESC_EOF    = 8'h95;
	localparam logic [7:0] LEN_OFFSET = 8'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] command;
		logic [7:0] payload_length;
		logic       first_item;
		logic       last_item;
	} bsfb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_frame;
	} bsfb_out_t;

	// Work entry handed from the front to the back.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [7:0]  command;
		logic [7:0]  payload_length;
		logic [15:0] seq;
		logic        first_item;
		logic        last_item;
	} bsfb_job_t;

	typedef enum logic [3:0] {
		ST_SOF1,
		ST_SOF2,
		ST_LEN,
		ST_SEQH,
		ST_SEQL,
		ST_CR,
		ST_CMD,
		ST_DATA,
		ST_SUM,
		ST_TAIL1,
		ST_TAIL2
	} bsfb_state_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == SOF1_BYTE) || (b == ESC_BYTE) || (b == EOF1_BYTE);
	endfunction

	function automatic logic [7:0] escape_code(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			SOF1_BYTE: r = ESC_SOF;
			ESC_BYTE:  r = ESC_ESC;
			EOF1_BYTE: r = ESC_EOF;
			default:   r = b;
		endcase
		return r;
	endfunction

endpackage

@@ src/bsfb_front.sv @@
// Front end: accepts items, drops those outside a frame, stamps sequence numbers.
module bsfb_front import bsfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  bsfb_in_t  item,
	input  logic      q_full,
	output logic      q_push,
	output bsfb_job_t q_job
);

	logic        in_frame_q;
	logic [15:0] seq_q;
	logic        accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept && (item.first_item || in_frame_q);

	always_comb begin
		q_job.data_byte      = item.data_byte;
		q_job.command        = item.command;
		q_job.payload_length = item.payload_length;
		q_job.seq            = seq_q;
		q_job.first_item     = item.first_item;
		q_job.last_item      = item.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			seq_q      <= 16'd0;
		end else if (q_push) begin
			in_frame_q <= !item.last_item;
			if (item.first_item) begin
				seq_q <= seq_q + 16'd1;
			end
		end
	end

endmodule

@@ src/bsfb_queue.sv @@
// Small work queue between the front and the back.
module bsfb_queue import bsfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  bsfb_job_t wr_job,
	output logic      q_full,
	input  logic      rd_en,
	output logic      q_empty,
	output bsfb_job_t rd_job
);

	bsfb_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/bsfb_back.sv @@
// Back end: emits header, stuffed data, checksum, tail; one byte a cycle unless stalled.
module bsfb_back import bsfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  bsfb_job_t q_job,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output bsfb_out_t result
);

	bsfb_state_t state_q, state_d;
	bsfb_job_t   job_q;
	logic        busy_q;
	logic        esc_q;
	logic [7:0]  sum_q;
	bsfb_out_t   out_q;
	logic        out_valid_q;

	logic        raw;
	logic [7:0]  raw_byte;
	logic [7:0]  stuff_val;
	logic        final_step;
	logic        hold;
	logic        final_byte;
	logic [7:0]  emit_byte;
	logic        adv;
	logic        done;

	assign empty  = !out_valid_q;
	assign result = out_q;
	assign adv    = busy_q && (!out_valid_q || pop);
	assign done   = adv && final_byte;
	assign q_pop  = (!busy_q || done) && !q_empty;

	always_comb begin
		raw        = 1'b0;
		raw_byte   = job_q.data_byte;
		stuff_val  = job_q.data_byte;
		final_step = 1'b0;
		state_d    = state_q;
		case (state_q)
			ST_SOF1: begin
				raw      = 1'b1;
				raw_byte = SOF1_BYTE;
				state_d  = ST_SOF2;
			end
			ST_SOF2: begin
				raw      = 1'b1;
				raw_byte = SOF2_BYTE;
				state_d  = ST_LEN;
			end
			ST_LEN: begin
				stuff_val = job_q.payload_length + LEN_OFFSET;
				state_d   = ST_SEQH;
			end
			ST_SEQH: begin
				stuff_val = job_q.seq[15:8];
				state_d   = ST_SEQL;
			end
			ST_SEQL: begin
				stuff_val = job_q.seq[7:0];
				state_d   = ST_CR;
			end
			ST_CR: begin
				stuff_val = CR_BYTE;
				state_d   = ST_CMD;
			end
			ST_CMD: begin
				stuff_val = job_q.command;
				state_d   = ST_DATA;
			end
			ST_DATA: begin
				stuff_val  = job_q.data_byte;
				final_step = !job_q.last_item;
				state_d    = job_q.last_item ? ST_SUM : ST_DATA;
			end
			ST_SUM: begin
				raw      = 1'b1;
				raw_byte = sum_q;
				state_d  = ST_TAIL1;
			end
			ST_TAIL1: begin
				raw      = 1'b1;
				raw_byte = EOF1_BYTE;
				state_d  = ST_TAIL2;
			end
			ST_TAIL2: begin
				raw        = 1'b1;
				raw_byte   = EOF2_BYTE;
				final_step = 1'b1;
				state_d    = ST_TAIL2;
			end
			default: begin
				state_d = ST_SOF1;
			end
		endcase

		// first pass over a special byte sends the escape marker and stays put
		hold = !raw && needs_escape(stuff_val) && !esc_q;
		if (hold) begin
			state_d = state_q;
		end
		final_byte = !hold && final_step;

		if (raw) begin
			emit_byte = raw_byte;
		end else if (hold) begin
			emit_byte = ESC_BYTE;
		end else if (esc_q) begin
			emit_byte = escape_code(stuff_val);
		end else begin
			emit_byte = stuff_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SOF1;
		end else if (q_pop) begin
			state_q <= q_job.first_item ? ST_SOF1 : ST_DATA;
		end else if (adv) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			esc_q       <= 1'b0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (q_pop) begin
				esc_q <= 1'b0;
			end else if (adv) begin
				esc_q <= hold;
			end

			if (adv) begin
				case (state_q)
					ST_SOF1:  sum_q <= SOF1_BYTE;
					ST_TAIL2: sum_q <= 8'd0;
					default:  sum_q <= sum_q + emit_byte;
				endcase
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (adv) begin
			out_q.out_byte     <= emit_byte;
			out_q.last_of_run  <= final_byte;
			out_q.end_of_frame <= (state_q == ST_TAIL2);
		end
	end

endmodule

@@ src/byte_stuffed_frame_builder.sv @@
// Top level of the byte-stuffed frame builder: front, work queue and back.
//
//   channel  | handshake          | transfer when        | payload
//   ---------+--------------------+----------------------+-----------
//   input    | push / full        | push && !full        | item
//   result   | empty / pop        | pop && !empty        | result
//
// The back emits one byte per cycle unless stalled: a plain payload byte is
// sent as 1 byte, an escaped one as 2, a frame-opening item adds 7 to 11
// bytes, a closing item 3. The front takes one item per cycle into a 4-entry
// queue; full rises when it fills. Items outside a frame are dropped at the
// front. Reset clears sequence number, frame flag, queue and output valid.
module byte_stuffed_frame_builder import bsfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  bsfb_in_t  item,
	output logic      empty,
	input  logic      pop,
	output bsfb_out_t result
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	bsfb_job_t wr_job;
	bsfb_job_t rd_job;

	bsfb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (wr_job)
	);

	bsfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_job  (wr_job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_job  (rd_job)
	);

	bsfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (rd_job),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
